>>> src/blcu_pkg.sv
// Shared constants, types and state encodings for the bit-plane life cell update block.
`default_nettype none

package blcu_pkg;

    localparam int PIXEL_W     = 24;
    localparam int IDX_W       = 8;
    localparam int SIZE_W      = 9;
    localparam int RULE_W      = 18;
    localparam int RULE_STRIDE = 9;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = RULE_W;
    localparam int CMDQ_DEPTH  = 2;
    localparam int NB_ROWS     = 3;

    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;

    localparam logic [CFG_ADDR_W-1:0] REG_RULE_MASK   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROWS_IN_USE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COLS_IN_USE = 2'd2;

    localparam logic [RULE_W-1:0] RULE_MASK_RST = 18'h01808;
    localparam logic [SIZE_W-1:0] ROWS_RST      = 9'd256;
    localparam logic [SIZE_W-1:0] COLS_RST      = 9'd256;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    typedef struct packed {
        logic               op;
        logic [IDX_W-1:0]   row_up;
        logic [IDX_W-1:0]   row_md;
        logic [IDX_W-1:0]   row_dn;
        logic [IDX_W-1:0]   col_lt;
        logic [IDX_W-1:0]   col_md;
        logic [IDX_W-1:0]   col_rt;
        logic [PIXEL_W-1:0] pixel;
    } cmd_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } fstate_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RD1,
        B_RD2,
        B_LAST
    } bstate_t;

endpackage

`default_nettype wire

>>> src/blcu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module blcu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/blcu_front.sv
// Front end: accepts words, reduces indices modulo the torus size, forms neighbor indices.
`default_nettype none

module blcu_front
    import blcu_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_push,
    output logic                    in_full,
    input  wire logic               in_opcode,
    input  wire logic [IDX_W-1:0]   in_row,
    input  wire logic [IDX_W-1:0]   in_col,
    input  wire logic [PIXEL_W-1:0] in_pixel,
    input  wire logic [SIZE_W-1:0]  rows_in_use,
    input  wire logic [SIZE_W-1:0]  cols_in_use,
    output logic                    q_push,
    input  wire logic               q_full,
    output cmd_t                    q_cmd
);

    localparam int LIM_ROWS = (MAX_ROWS < (1 << IDX_W)) ? MAX_ROWS : (1 << IDX_W);
    localparam int LIM_COLS = (MAX_COLS < (1 << IDX_W)) ? MAX_COLS : (1 << IDX_W);
    localparam int DIV_CYC  = IDX_W / 2;
    localparam int STEP_W   = $clog2(DIV_CYC);

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                   input logic [SIZE_W-1:0] lim);
        if (r == '0)
            return SIZE_W'(1);
        else if (r > lim)
            return lim;
        else
            return r;
    endfunction

    // one restoring remainder step
    function automatic logic [IDX_W-1:0] mod_step(input logic [IDX_W-1:0] rem,
                                                  input logic b,
                                                  input logic [SIZE_W-1:0] d);
        logic [SIZE_W-1:0] t;
        t = {rem, b};
        if (t >= d)
            return IDX_W'(t - d);
        else
            return t[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] dec_wrap(input logic [IDX_W-1:0] i,
                                                  input logic [SIZE_W-1:0] sz);
        if (i == '0)
            return IDX_W'(sz - SIZE_W'(1));
        else
            return i - IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] i,
                                                  input logic [SIZE_W-1:0] sz);
        if (({1'b0, i} + SIZE_W'(1)) == sz)
            return '0;
        else
            return i + IDX_W'(1);
    endfunction

    fstate_t             state_reg, state_next;
    logic                op_reg, op_next;
    logic [PIXEL_W-1:0]  pix_reg, pix_next;
    logic [IDX_W-1:0]    rdiv_reg, rdiv_next;
    logic [IDX_W-1:0]    cdiv_reg, cdiv_next;
    logic [IDX_W-1:0]    rrem_reg, rrem_next;
    logic [IDX_W-1:0]    crem_reg, crem_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SIZE_W-1:0]   rows_eff, cols_eff;
    logic                accept;
    logic                in_range;
    logic [IDX_W-1:0]    r_mid, c_mid;

    assign rows_eff = eff_size(rows_in_use, SIZE_W'(LIM_ROWS));
    assign cols_eff = eff_size(cols_in_use, SIZE_W'(LIM_COLS));

    assign in_full  = !((state_reg == F_IDLE) || (state_reg == F_PUSH && !q_full));
    assign accept   = in_push && !in_full;
    assign in_range = ({1'b0, in_row} < rows_eff) && ({1'b0, in_col} < cols_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        pix_reg  <= pix_next;
        rdiv_reg <= rdiv_next;
        cdiv_reg <= cdiv_next;
        rrem_reg <= rrem_next;
        crem_reg <= crem_next;
        step_reg <= step_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        pix_next   = pix_reg;
        rdiv_next  = rdiv_reg;
        cdiv_next  = cdiv_reg;
        rrem_next  = rrem_reg;
        crem_next  = crem_reg;
        step_next  = step_reg;
        r_mid      = '0;
        c_mid      = '0;

        unique case (state_reg)
            F_IDLE:
            begin
            end
            F_DIV:
            begin
                // two dividend bits per cycle, row and column side by side
                r_mid     = mod_step(rrem_reg, rdiv_reg[IDX_W-1], rows_eff);
                c_mid     = mod_step(crem_reg, cdiv_reg[IDX_W-1], cols_eff);
                rrem_next = mod_step(r_mid, rdiv_reg[IDX_W-2], rows_eff);
                crem_next = mod_step(c_mid, cdiv_reg[IDX_W-2], cols_eff);
                rdiv_next = rdiv_reg << 2;
                cdiv_next = cdiv_reg << 2;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_CYC - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase

        if (accept)
        begin
            op_next  = in_opcode;
            pix_next = in_pixel;
            if (in_range)
            begin
                rrem_next  = in_row;
                crem_next  = in_col;
                state_next = F_PUSH;
            end
            else
            begin
                rdiv_next  = in_row;
                cdiv_next  = in_col;
                rrem_next  = '0;
                crem_next  = '0;
                step_next  = '0;
                state_next = F_DIV;
            end
        end
    end

    assign q_push       = (state_reg == F_PUSH) && !q_full;
    assign q_cmd.op     = op_reg;
    assign q_cmd.row_up = dec_wrap(rrem_reg, rows_eff);
    assign q_cmd.row_md = rrem_reg;
    assign q_cmd.row_dn = inc_wrap(rrem_reg, rows_eff);
    assign q_cmd.col_lt = dec_wrap(crem_reg, cols_eff);
    assign q_cmd.col_md = crem_reg;
    assign q_cmd.col_rt = inc_wrap(crem_reg, cols_eff);
    assign q_cmd.pixel  = pix_reg;

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_PUSH) |-> (({1'b0, rrem_reg} < rows_eff) && ({1'b0, crem_reg} < cols_eff)))
        else $error("front: reduced index not below torus size");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_DIV && step_reg == STEP_W'(DIV_CYC - 1)) |=> (state_reg == F_PUSH))
        else $error("front: remainder iteration did not finish on time");

endmodule

`default_nettype wire

>>> src/blcu_cmd_queue.sv
// Short command queue between front end and back end.
`default_nettype none

module blcu_cmd_queue
    import blcu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t wdata,
    output logic      full,
    input  wire logic pop,
    output cmd_t      rdata,
    output logic      empty
);

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t             entry_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(CMDQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("cmd queue: push while full");

endmodule

`default_nettype wire

>>> src/blcu_back.sv
// Back end: image store copies, neighbour read sequencer, per-plane count and rule lookup.
`default_nettype none

module blcu_back
    import blcu_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    input  wire cmd_t               q_cmd,
    output logic                    q_pop,
    input  wire logic [RULE_W-1:0]  rule_mask,
    output logic                    res_empty,
    input  wire logic               res_pop,
    output logic [PIXEL_W-1:0]      res_pixel
);

    localparam int LIM_ROWS = (MAX_ROWS < (1 << IDX_W)) ? MAX_ROWS : (1 << IDX_W);
    localparam int LIM_COLS = (MAX_COLS < (1 << IDX_W)) ? MAX_COLS : (1 << IDX_W);
    localparam int ROW_W    = $clog2(LIM_ROWS);
    localparam int COL_W    = $clog2(LIM_COLS);
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int CNT_W    = 3;
    localparam int TOT_W    = 4;
    localparam int RIDX_W   = $clog2(RULE_W);

    bstate_t             state_reg, state_next;
    cmd_t                cmd_reg;
    logic [CNT_W-1:0]    cnt_reg  [PIXEL_W];
    logic [CNT_W-1:0]    cnt_next [PIXEL_W];
    logic [PIXEL_W-1:0]  alive_reg, alive_next;
    logic                out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0]  out_pixel_reg, out_pixel_next;

    logic                out_free;
    logic                start;
    logic                wr_en, rd_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr [NB_ROWS];
    logic [PIXEL_W-1:0]  rd_data [NB_ROWS];
    logic [IDX_W-1:0]    rd_row  [NB_ROWS];
    logic [IDX_W-1:0]    rd_col;
    cmd_t                issue_cmd;
    logic [PIXEL_W-1:0]  new_pixel;

    assign out_free  = !out_valid_reg || res_pop;
    assign start     = (state_reg == B_IDLE) || (state_reg == B_LAST && out_free);
    assign q_pop     = start && !q_empty;
    assign wr_en     = q_pop && (q_cmd.op == OP_WRITE);
    assign rd_en     = (q_pop && (q_cmd.op == OP_COMPUTE)) ||
                       (state_reg == B_RD1) || (state_reg == B_RD2);
    assign wr_addr   = {q_cmd.row_md[ROW_W-1:0], q_cmd.col_md[COL_W-1:0]};
    assign issue_cmd = ((state_reg == B_RD1) || (state_reg == B_RD2)) ? cmd_reg : q_cmd;
    assign res_empty = !out_valid_reg;
    assign res_pixel = out_pixel_reg;

    always_comb
    begin
        rd_row[0] = issue_cmd.row_up;
        rd_row[1] = issue_cmd.row_md;
        rd_row[2] = issue_cmd.row_dn;
        case (state_reg)
            B_RD1:   rd_col = issue_cmd.col_md;
            B_RD2:   rd_col = issue_cmd.col_rt;
            default: rd_col = issue_cmd.col_lt;
        endcase
    end

    // one full image copy per neighbour row, so three rows read per cycle
    for (genvar k = 0; k < NB_ROWS; k++)
    begin : g_copy
        assign rd_addr[k] = {rd_row[k][ROW_W-1:0], rd_col[COL_W-1:0]};

        blcu_ram #(
            .WIDTH (PIXEL_W),
            .DEPTH (2 ** ADDR_W)
        ) u_ram (
            .clk   (clk),
            .we    (wr_en),
            .waddr (wr_addr),
            .wdata (q_cmd.pixel),
            .re    (rd_en),
            .raddr (rd_addr[k]),
            .rdata (rd_data[k])
        );
    end

    always_comb
    begin
        logic [TOT_W-1:0]  tot;
        logic [RIDX_W-1:0] ridx;
        for (int b = 0; b < PIXEL_W; b++)
        begin
            cnt_next[b] = cnt_reg[b];
        end
        alive_next = alive_reg;
        new_pixel  = '0;
        tot        = '0;
        ridx       = '0;

        for (int b = 0; b < PIXEL_W; b++)
        begin
            case (state_reg)
                B_RD1:
                begin
                    cnt_next[b] = CNT_W'(rd_data[0][b]) + CNT_W'(rd_data[1][b]) +
                                  CNT_W'(rd_data[2][b]);
                end
                B_RD2:
                begin
                    cnt_next[b] = cnt_reg[b] + CNT_W'(rd_data[0][b]) + CNT_W'(rd_data[2][b]);
                    alive_next[b] = rd_data[1][b];
                end
                B_LAST:
                begin
                    tot = TOT_W'(cnt_reg[b]) + TOT_W'(rd_data[0][b]) +
                          TOT_W'(rd_data[1][b]) + TOT_W'(rd_data[2][b]);
                    ridx = alive_reg[b] ? RIDX_W'(tot) + RIDX_W'(RULE_STRIDE) : RIDX_W'(tot);
                    new_pixel[b] = rule_mask[ridx];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_pixel_next = out_pixel_reg;

        if (res_pop)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_pop && q_cmd.op == OP_COMPUTE)
                begin
                    state_next = B_RD1;
                end
            end
            B_RD1:
            begin
                state_next = B_RD2;
            end
            B_RD2:
            begin
                state_next = B_LAST;
            end
            B_LAST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pixel_next = new_pixel;
                    if (q_pop && q_cmd.op == OP_COMPUTE)
                        state_next = B_RD1;
                    else
                        state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        cnt_reg       <= cnt_next;
        alive_reg     <= alive_next;
        out_pixel_reg <= out_pixel_next;
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back: command taken from empty queue");

    a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_RD1) |=> (state_reg == B_RD2))
        else $error("back: neighbour read sequence broken");

    a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_LAST && out_valid_reg && !res_pop) |=> (state_reg == B_LAST))
        else $error("back: result dropped while output slot busy");

endmodule

`default_nettype wire

>>> src/bitplane_life_cell_update.sv
// Top level of the bit-plane life cell update block: config registers, front, queue, back.
//
//  channel   dir  handshake               word
//  input     in   push / full             opcode, row_index, col_index, pixel_in
//  result    out  empty / pop             pixel_out
//  config    in   cfg_we (no wait)        cfg_addr, cfg_wdata
//
// Front end: an index pair below the torus size is registered and goes straight to the
// push state; otherwise row and column remainders are first formed in the divide
// state (two quotient bits a cycle). Back end: a write is stored as it leaves the queue;
// a compute reads left, middle and right columns in turn, each image copy giving one
// neighbour row per read; the next is popped in the rule lookup. Results appear in order.
// A busy result slot stalls the back end; the 2-entry queue lets the front keep going.
// Reset clears control state only; the image store is undefined until written.
`default_nettype none

module bitplane_life_cell_update
    import blcu_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  opcode,
    input  wire logic [IDX_W-1:0]      row_index,
    input  wire logic [IDX_W-1:0]      col_index,
    input  wire logic [PIXEL_W-1:0]    pixel_in,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [PIXEL_W-1:0]         pixel_out,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [RULE_W-1:0] rule_mask_reg;
    logic [SIZE_W-1:0] rows_in_use_reg;
    logic [SIZE_W-1:0] cols_in_use_reg;

    logic q_push, q_full, q_pop, q_empty;
    cmd_t q_wcmd, q_rcmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_mask_reg   <= RULE_MASK_RST;
            rows_in_use_reg <= ROWS_RST;
            cols_in_use_reg <= COLS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_RULE_MASK:   rule_mask_reg   <= cfg_wdata[RULE_W-1:0];
                REG_ROWS_IN_USE: rows_in_use_reg <= cfg_wdata[SIZE_W-1:0];
                REG_COLS_IN_USE: cols_in_use_reg <= cfg_wdata[SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    blcu_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_push     (push),
        .in_full     (full),
        .in_opcode   (opcode),
        .in_row      (row_index),
        .in_col      (col_index),
        .in_pixel    (pixel_in),
        .rows_in_use (rows_in_use_reg),
        .cols_in_use (cols_in_use_reg),
        .q_push      (q_push),
        .q_full      (q_full),
        .q_cmd       (q_wcmd)
    );

    blcu_cmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wcmd),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rcmd),
        .empty (q_empty)
    );

    blcu_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (q_rcmd),
        .q_pop     (q_pop),
        .rule_mask (rule_mask_reg),
        .res_empty (empty),
        .res_pop   (pop),
        .res_pixel (pixel_out)
    );

endmodule

`default_nettype wire
